// File: rtl/fpbcd_pkg.sv
// ----------------------------------------------------------------------------
// fpbcd_pkg
// Types, widths and helper functions for the fixed-point to signed BCD
// converter.
// ----------------------------------------------------------------------------
package fpbcd_pkg;

    localparam int MAG_W          = 32;              // magnitude of the measurement
    localparam int SCALE_W        = 14;              // holds 10^4
    localparam int PROD_W         = MAG_W + SCALE_W; // scaled magnitude
    localparam int BCD_W          = 32;              // eight packed digits
    localparam int DIGITS         = BCD_W / 4;
    localparam int BITS_PER_STAGE = 8;               // shift-add-3 steps per stage
    localparam int MAX_DECIMALS   = 4;
    localparam int MAX_BYTES      = 4;

    // Per-item format that travels alongside the arithmetic.
    typedef struct packed {
        logic [31:0] mask;
        logic        neg;
        logic [4:0]  spos;
        logic [2:0]  nbytes;
    } sideband_t;

    // Ten to the power of the decimal count; counts above four saturate.
    function automatic logic [SCALE_W-1:0] pow10_scale(input logic [2:0] dec);
        logic [SCALE_W-1:0] s;
        case (dec)
            3'd0:    s = SCALE_W'(1);
            3'd1:    s = SCALE_W'(10);
            3'd2:    s = SCALE_W'(100);
            3'd3:    s = SCALE_W'(1000);
            default: s = SCALE_W'(10000);
        endcase
        return s;
    endfunction

    // Byte count limited to the range one to four.
    function automatic logic [2:0] clamp_bytes(input logic [2:0] b);
        logic [2:0] r;
        if (b == 3'd0) begin
            r = 3'd1;
        end else if (b > 3'(MAX_BYTES)) begin
            r = 3'(MAX_BYTES);
        end else begin
            r = b;
        end
        return r;
    endfunction

    // One double-dabble step: adjust every digit, then shift in the next bit.
    // The carry out of the top digit is dropped, which keeps the value
    // modulo 10^8 exactly.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

// File: rtl/fixed_point_to_signed_bcd.sv
// ----------------------------------------------------------------------------
// fixed_point_to_signed_bcd
// Converts a fixed-point measurement into masked, signed packed BCD.
// ----------------------------------------------------------------------------
// Usage
//   Input items arrive on the s_ stream: tdata carries the raw value, decimal
//   count, digit mask, sign position and byte count; tuser carries the
//   signed-mode flag. Each item gives exactly one result on the m_ stream:
//   the packed BCD word and the number of meaningful low bytes.
//   The block is a pipeline: an input stage (magnitude and format), a
//   32 x 14 bit multiplier stage, a rounding stage, one double-dabble stage
//   per eight bits of the rounded value, and the output register.
//   Throughput is one item per cycle while the receiver keeps m_tready high;
//   each stage holds one item.
//   When the receiver stalls, the output register holds its item and the
//   stages behind it keep filling; s_tready falls only once every stage
//   holds an item.
//   Reset clears all stage valid flags; no result is pending afterwards.
// ----------------------------------------------------------------------------
module fixed_point_to_signed_bcd
    import fpbcd_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // raw_value[31:0], decimals[34:32], digit_mask[66:35], sign_bit_pos[71:67],
    // byte_count[74:72], zero padding above
    input  logic [79:0] s_tdata,
    // signed_mode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bcd_word[31:0], valid_bytes[34:32], zero padding above
    output logic [39:0] m_tdata
);

    localparam int ROUND_W = PROD_W - FRAC_BITS;
    localparam int NSTG    = (ROUND_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PADW    = NSTG * BITS_PER_STAGE;
    localparam int NS      = 4 + NSTG;     // input, multiply, round, dabble, output
    localparam int ST_A    = 0;
    localparam int ST_B    = 1;
    localparam int ST_C    = 2;
    localparam int ST_D    = 3;
    localparam int ST_OUT  = NS - 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'((64'd1 << FRAC_BITS) >> 1);

    // Input fields
    logic [31:0] in_raw;
    logic [2:0]  in_dec;
    logic [31:0] in_mask;
    logic [4:0]  in_spos;
    logic [2:0]  in_bytes;
    logic        in_smode;
    logic        in_neg;

    assign in_raw   = s_tdata[31:0];
    assign in_dec   = s_tdata[34:32];
    assign in_mask  = s_tdata[66:35];
    assign in_spos  = s_tdata[71:67];
    assign in_bytes = s_tdata[74:72];
    assign in_smode = s_tuser;
    assign in_neg   = in_smode & in_raw[31];

    // Pipeline control
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] adv;
    sideband_t     sb_reg [NS-1];

    always_comb begin
        adv[ST_OUT] = !valid_reg[ST_OUT] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[ST_A];

    // Stage A: magnitude and scale factor. Two's complement negation already
    // gives 2^31 for the most negative input.
    logic [MAG_W-1:0]   mag_reg;
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_A]) begin
            mag_reg         <= in_neg ? (~in_raw + 32'd1) : in_raw;
            scale_reg       <= pow10_scale(in_dec);
            sb_reg[ST_A]    <= '{mask: in_mask, neg: in_neg, spos: in_spos,
                                 nbytes: clamp_bytes(in_bytes)};
        end
    end

    // Stage B: scaling multiply
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_B]) begin
            prod_reg     <= PROD_W'(mag_reg) * PROD_W'(scale_reg);
            sb_reg[ST_B] <= sb_reg[ST_A];
        end
    end

    // Stage C: round half up; the sum stays below 2^46 for any input.
    logic [PROD_W-1:0] sum_rnd;
    logic [PADW-1:0]   rnd_reg;

    assign sum_rnd = prod_reg + HALF;

    always_ff @(posedge aclk) begin
        if (adv[ST_C]) begin
            rnd_reg      <= PADW'(ROUND_W'(sum_rnd >> FRAC_BITS));
            sb_reg[ST_C] <= sb_reg[ST_B];
        end
    end

    // Dabble stages: each takes the next eight bits, most significant first.
    logic [BCD_W-1:0] bcd_reg [NSTG];
    logic [PADW-1:0]  rem_reg [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_dabble
        logic [BCD_W-1:0] bcd_in;
        logic [PADW-1:0]  rem_in;
        logic [BCD_W-1:0] bcd_step;

        if (k == 0) begin : g_first
            assign bcd_in = '0;
            assign rem_in = rnd_reg;
        end else begin : g_rest
            assign bcd_in = bcd_reg[k-1];
            assign rem_in = rem_reg[k-1];
        end

        always_comb begin
            logic [BCD_W-1:0] acc;
            acc = bcd_in;
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                acc = dd_step(acc, rem_in[PADW-1-j]);
            end
            bcd_step = acc;
        end

        always_ff @(posedge aclk) begin
            if (adv[ST_D+k]) begin
                bcd_reg[k]      <= bcd_step;
                rem_reg[k]      <= rem_in << BITS_PER_STAGE;
                sb_reg[ST_D+k]  <= sb_reg[ST_D+k-1];
            end
        end
    end

    // Output register: mask the digits and merge the sign flag.
    sideband_t        sb_last;
    logic [BCD_W-1:0] flag_word;
    logic [BCD_W-1:0] word_reg;
    logic [2:0]       bytes_reg;

    assign sb_last   = sb_reg[ST_OUT-1];
    assign flag_word = BCD_W'(sb_last.neg) << sb_last.spos;

    always_ff @(posedge aclk) begin
        if (adv[ST_OUT]) begin
            word_reg  <= (bcd_reg[NSTG-1] & sb_last.mask) | flag_word;
            bytes_reg <= sb_last.nbytes;
        end
    end

    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = {5'd0, bytes_reg, word_reg};

    // Checks
    a_no_reset_result: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid straight after reset");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && valid_reg == '1))
        else $error("input stalled while the pipeline has room");

    a_neg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_A] && sb_reg[ST_A].neg) |-> (mag_reg != '0))
        else $error("negative input gave a zero magnitude");

    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (bytes_reg >= 3'd1 && bytes_reg <= 3'(MAX_BYTES)))
        else $error("byte count out of range");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_C] && !adv[ST_C]) |=> (valid_reg[ST_C] && $stable(rnd_reg)))
        else $error("rounding stage lost a stalled item");

endmodule
